>>> hdl/uart_register_access_host_unit_defines.svh
// ----------------------------------------------------------------------------
// UART register access host - assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_ACCESS_HOST_UNIT_DEFINES_SVH
`define UART_REGISTER_ACCESS_HOST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UARH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UARH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/uarh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register access host - package
// Protocol bytes, operation and result codes, and the types shared by the
// sequencer, the result emitter and the top level.
// ----------------------------------------------------------------------------
package uarh_pkg;

  // Field widths fixed by the protocol.
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned NUM_CNT = 4;

  // Frame bytes.
  localparam logic [7:0] BYTE_SYNC      = 8'hAA;
  localparam logic [7:0] BYTE_CMD_READ  = 8'h01;
  localparam logic [7:0] BYTE_CMD_WRITE = 8'h00;
  localparam logic [7:0] BYTE_WR_LEN    = 8'h01;
  localparam logic [7:0] BYTE_RESP_HDR  = 8'hBB;
  localparam logic [7:0] BYTE_RESP_ERR  = 8'hEE;
  localparam logic [7:0] BYTE_ACK_OK    = 8'h01;

  // Chip error codes used for classification.
  localparam logic [7:0] CODE_NO_ANSWER = 8'hFF;
  localparam logic [7:0] CODE_OVERRUN   = 8'h07;
  localparam logic [7:0] CODE_BAD_HDR   = 8'hFE;
  localparam logic [7:0] CODE_BAD_DATA  = 8'hFD;

  // Reset value of the timeout register.
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd30;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_ANSWER     = 3'd1,
    ST_CHIP_ERROR    = 3'd2,
    ST_BAD_FRAME     = 3'd3,
    ST_SHORT_DATA    = 3'd4,
    ST_WRITE_REFUSED = 3'd5,
    ST_BAD_LENGTH    = 3'd6,
    ST_BUSY          = 3'd7
  } status_e;

  // Error counter slots.
  typedef enum logic [1:0] {
    CLS_NO_ANSWER = 2'd0,
    CLS_OVERRUN   = 2'd1,
    CLS_FORMAT    = 2'd2,
    CLS_OTHER     = 2'd3
  } cls_e;

  // Protocol phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_ACK1 = 6'b010000,
    PH_ACK2 = 6'b100000
  } phase_e;

  // Kind of result burst handed from the sequencer to the emitter.
  typedef enum logic [2:0] {
    D_NONE   = 3'd0,
    D_RDCMD  = 3'd1,
    D_WRCMD  = 3'd2,
    D_DATA   = 3'd3,
    D_STATUS = 3'd4
  } desc_e;

  // Burst descriptor. value is the write byte for a write command and the
  // final data byte for a data burst.
  typedef struct packed {
    desc_e            kind;
    logic [7:0]       reg_addr;
    logic [LEN_W-1:0] length;
    logic [7:0]       value;
    status_e          status;
    logic [7:0]       code;
  } desc_t;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_arr_t;

  // Map a chip error code onto its counter slot.
  function automatic cls_e classify(input logic [7:0] code);
    cls_e cls;
    if (code == CODE_NO_ANSWER) begin
      cls = CLS_NO_ANSWER;
    end else if (code == CODE_OVERRUN) begin
      cls = CLS_OVERRUN;
    end else if (code == CODE_BAD_HDR || code == CODE_BAD_DATA) begin
      cls = CLS_FORMAT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

>>> hdl/uarh_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register access host - protocol sequencer
// Registers the incoming word, runs the request/response state machine,
// buffers read data, keeps the error counters and describes the results.
// ----------------------------------------------------------------------------
module uarh_seq #(
  parameter int unsigned MAX_READ_BYTES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  input  logic [31:0]                           s_tdata_i,
  input  logic [1:0]                            s_tuser_i,
  input  logic [uarh_pkg::TIMER_W-1:0]          timeout_i,
  input  logic                                  can_take_i,
  output logic                                  desc_valid_o,
  output uarh_pkg::desc_t                       desc_o,
  output uarh_pkg::cnt_arr_t                    cnt_o,
  input  logic [(MAX_READ_BYTES > 1 ? $clog2(MAX_READ_BYTES) : 1)-1:0] rd_idx_i,
  output logic [7:0]                            rd_data_o
);

  localparam int unsigned IDX_W = (MAX_READ_BYTES > 1) ? $clog2(MAX_READ_BYTES) : 1;
  localparam logic [uarh_pkg::LEN_W-1:0] MAX_LEN = uarh_pkg::LEN_W'(MAX_READ_BYTES);

  // Input register.
  logic                        in_valid_q;
  uarh_pkg::op_e               op_q;
  logic [7:0]                  reg_q;
  logic [uarh_pkg::LEN_W-1:0]  rl_q;
  logic [7:0]                  wv_q;
  logic [7:0]                  rx_q;
  logic                        process;

  // Protocol state.
  uarh_pkg::phase_e              phase_q, phase_d;
  logic [uarh_pkg::LEN_W-1:0]    pend_q, pend_d;
  logic [uarh_pkg::LEN_W-1:0]    seen_q, seen_d;
  logic [7:0]                    hdr_q, hdr_d;
  logic [uarh_pkg::TIMER_W-1:0]  timer_q, timer_d;
  logic [uarh_pkg::TIMER_W-1:0]  timer_inc;
  uarh_pkg::cnt_arr_t            cnt_q, cnt_d;
  logic [7:0]                    buf_q [MAX_READ_BYTES];

  // Combinational results of the current word.
  uarh_pkg::desc_t               desc;
  logic                          inc_en;
  uarh_pkg::cls_e                inc_cls;
  logic                          buf_we;
  logic [uarh_pkg::LEN_W-1:0]    seen_inc;

  assign process    = in_valid_q && (can_take_i || desc.kind == uarh_pkg::D_NONE);
  assign s_tready_o = !in_valid_q || process;

  // Capture a word whenever the register is free or being consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      op_q  <= uarh_pkg::op_e'(s_tuser_i);
      reg_q <= s_tdata_i[7:0];
      rl_q  <= s_tdata_i[13:8];
      wv_q  <= s_tdata_i[21:14];
      rx_q  <= s_tdata_i[29:22];
    end
  end

  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
  assign seen_inc  = seen_q + 1'b1;

  // Next state and result descriptor for the registered word.
  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    seen_d  = seen_q;
    hdr_d   = hdr_q;
    timer_d = timer_q;
    inc_en  = 1'b0;
    inc_cls = uarh_pkg::CLS_NO_ANSWER;
    buf_we  = 1'b0;
    desc          = '0;
    desc.kind     = uarh_pkg::D_NONE;
    desc.status   = uarh_pkg::ST_OK;
    desc.reg_addr = reg_q;
    case (op_q)
      uarh_pkg::OP_READ, uarh_pkg::OP_WRITE: begin
        if (phase_q != uarh_pkg::PH_IDLE) begin
          desc.kind   = uarh_pkg::D_STATUS;
          desc.status = uarh_pkg::ST_BUSY;
        end else if (op_q == uarh_pkg::OP_READ && (rl_q == '0 || rl_q > MAX_LEN)) begin
          desc.kind   = uarh_pkg::D_STATUS;
          desc.status = uarh_pkg::ST_BAD_LENGTH;
        end else begin
          seen_d  = '0;
          hdr_d   = '0;
          timer_d = '0;
          if (op_q == uarh_pkg::OP_READ) begin
            desc.kind   = uarh_pkg::D_RDCMD;
            desc.length = rl_q;
            pend_d      = rl_q;
            phase_d     = uarh_pkg::PH_HDR;
          end else begin
            desc.kind  = uarh_pkg::D_WRCMD;
            desc.value = wv_q;
            pend_d     = '0;
            phase_d    = uarh_pkg::PH_ACK1;
          end
        end
      end
      uarh_pkg::OP_RX: begin
        case (phase_q)
          uarh_pkg::PH_HDR: begin
            hdr_d   = rx_q;
            phase_d = uarh_pkg::PH_LEN;
          end
          uarh_pkg::PH_LEN: begin
            if (hdr_q == uarh_pkg::BYTE_RESP_ERR) begin
              inc_en      = 1'b1;
              inc_cls     = uarh_pkg::classify(rx_q);
              desc.kind   = uarh_pkg::D_STATUS;
              desc.status = uarh_pkg::ST_CHIP_ERROR;
              desc.code   = rx_q;
              phase_d     = uarh_pkg::PH_IDLE;
              timer_d     = '0;
            end else if (hdr_q != uarh_pkg::BYTE_RESP_HDR || rx_q != {2'b00, pend_q}) begin
              inc_en      = 1'b1;
              inc_cls     = uarh_pkg::classify(uarh_pkg::CODE_BAD_HDR);
              desc.kind   = uarh_pkg::D_STATUS;
              desc.status = uarh_pkg::ST_BAD_FRAME;
              phase_d     = uarh_pkg::PH_IDLE;
              timer_d     = '0;
            end else begin
              phase_d = uarh_pkg::PH_DATA;
              seen_d  = '0;
              timer_d = '0;
            end
          end
          uarh_pkg::PH_DATA: begin
            buf_we = (seen_q < MAX_LEN);
            seen_d = seen_inc;
            if (seen_inc >= pend_q) begin
              desc.kind   = uarh_pkg::D_DATA;
              desc.length = pend_q;
              desc.value  = rx_q;
              phase_d     = uarh_pkg::PH_IDLE;
              timer_d     = '0;
            end
          end
          uarh_pkg::PH_ACK1: begin
            hdr_d   = rx_q;
            phase_d = uarh_pkg::PH_ACK2;
          end
          uarh_pkg::PH_ACK2: begin
            desc.kind = uarh_pkg::D_STATUS;
            if (hdr_q == uarh_pkg::BYTE_RESP_ERR && rx_q == uarh_pkg::BYTE_ACK_OK) begin
              desc.status = uarh_pkg::ST_OK;
            end else begin
              desc.status = uarh_pkg::ST_WRITE_REFUSED;
            end
            phase_d = uarh_pkg::PH_IDLE;
            timer_d = '0;
          end
          default: begin
            phase_d = uarh_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
        // Timer tick: only counts while a response is awaited.
        if (phase_q != uarh_pkg::PH_IDLE) begin
          if (timer_inc < timeout_i) begin
            timer_d = timer_inc;
          end else begin
            phase_d   = uarh_pkg::PH_IDLE;
            timer_d   = '0;
            desc.kind = uarh_pkg::D_STATUS;
            if (phase_q == uarh_pkg::PH_DATA) begin
              inc_en      = 1'b1;
              inc_cls     = uarh_pkg::classify(uarh_pkg::CODE_BAD_DATA);
              desc.status = uarh_pkg::ST_SHORT_DATA;
            end else begin
              inc_en      = (phase_q == uarh_pkg::PH_HDR || phase_q == uarh_pkg::PH_LEN);
              inc_cls     = uarh_pkg::classify(uarh_pkg::CODE_NO_ANSWER);
              desc.status = uarh_pkg::ST_NO_ANSWER;
            end
          end
        end
      end
    endcase
  end

  // Saturating error counters; they only move when the word is processed.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < uarh_pkg::NUM_CNT; i++) begin
      if (process && inc_en && inc_cls == uarh_pkg::cls_e'(i) && cnt_q[i] != '1) begin
        cnt_d[i] = cnt_q[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uarh_pkg::PH_IDLE;
      pend_q  <= '0;
      seen_q  <= '0;
      hdr_q   <= '0;
      timer_q <= '0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (process) begin
        phase_q <= phase_d;
        pend_q  <= pend_d;
        seen_q  <= seen_d;
        hdr_q   <= hdr_d;
        timer_q <= timer_d;
      end
    end
  end

  // Read data buffer.
  always_ff @(posedge clk_i) begin
    if (process && buf_we) begin
      buf_q[seen_q[IDX_W-1:0]] <= rx_q;
    end
  end

  assign rd_data_o    = buf_q[rd_idx_i];
  assign desc_valid_o = process;
  assign desc_o       = desc;
  assign cnt_o        = cnt_d;

endmodule

>>> hdl/uarh_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register access host - result emitter
// Expands a burst descriptor into result words, one per cycle while the
// output is not stalled, through the output register.
// ----------------------------------------------------------------------------
module uarh_emit #(
  parameter int unsigned MAX_READ_BYTES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  desc_valid_i,
  input  uarh_pkg::desc_t                       desc_i,
  input  uarh_pkg::cnt_arr_t                    cnt_i,
  output logic                                  can_take_o,
  output logic [(MAX_READ_BYTES > 1 ? $clog2(MAX_READ_BYTES) : 1)-1:0] rd_idx_o,
  input  logic [7:0]                            rd_data_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [159:0]                          m_tdata_o,
  output logic [1:0]                            m_tuser_o,
  output logic                                  m_tlast_o
);

  localparam int unsigned IDX_W = (MAX_READ_BYTES > 1) ? $clog2(MAX_READ_BYTES) : 1;

  // Burst state.
  logic                        busy_q;
  uarh_pkg::desc_t             hold_q;
  logic [uarh_pkg::LEN_W-1:0]  idx_q;

  // Output register.
  logic                        out_valid_q;
  uarh_pkg::kind_e             out_kind_q;
  logic [7:0]                  out_tx_q;
  logic [7:0]                  out_data_q;
  uarh_pkg::status_e           out_status_q;
  logic [7:0]                  out_code_q;
  logic                        out_last_q;
  uarh_pkg::cnt_arr_t          out_cnt_q;

  uarh_pkg::desc_t             cur;
  logic [uarh_pkg::LEN_W-1:0]  cur_idx;
  logic [uarh_pkg::LEN_W-1:0]  count;
  logic                        is_last;
  logic                        out_free;
  logic                        gen;
  uarh_pkg::kind_e             res_kind;
  logic [7:0]                  res_tx;
  logic [7:0]                  res_data;
  uarh_pkg::status_e           res_status;
  logic [7:0]                  res_code;

  assign out_free   = !out_valid_q || m_tready_i;
  assign can_take_o = !busy_q && out_free;
  assign cur        = busy_q ? hold_q : desc_i;
  assign cur_idx    = busy_q ? idx_q : '0;
  assign rd_idx_o   = cur_idx[IDX_W-1:0];
  assign gen = out_free &&
               (busy_q || (desc_valid_i && desc_i.kind != uarh_pkg::D_NONE));

  // Number of result words in the current burst.
  always_comb begin
    case (cur.kind)
      uarh_pkg::D_RDCMD:  count = uarh_pkg::LEN_W'(4);
      uarh_pkg::D_WRCMD:  count = uarh_pkg::LEN_W'(5);
      uarh_pkg::D_DATA:   count = cur.length;
      uarh_pkg::D_STATUS: count = uarh_pkg::LEN_W'(1);
      default:            count = '0;
    endcase
  end

  assign is_last = (cur_idx == count - 1'b1);

  // Build the word at the current burst position.
  always_comb begin
    res_kind   = uarh_pkg::KIND_STATUS;
    res_tx     = '0;
    res_data   = '0;
    res_status = uarh_pkg::ST_OK;
    res_code   = '0;
    case (cur.kind)
      uarh_pkg::D_RDCMD: begin
        res_kind = uarh_pkg::KIND_TX;
        case (cur_idx[1:0])
          2'd0:    res_tx = uarh_pkg::BYTE_SYNC;
          2'd1:    res_tx = uarh_pkg::BYTE_CMD_READ;
          2'd2:    res_tx = cur.reg_addr;
          default: res_tx = {2'b00, cur.length};
        endcase
      end
      uarh_pkg::D_WRCMD: begin
        res_kind = uarh_pkg::KIND_TX;
        case (cur_idx[2:0])
          3'd0:    res_tx = uarh_pkg::BYTE_SYNC;
          3'd1:    res_tx = uarh_pkg::BYTE_CMD_WRITE;
          3'd2:    res_tx = cur.reg_addr;
          3'd3:    res_tx = uarh_pkg::BYTE_WR_LEN;
          default: res_tx = cur.value;
        endcase
      end
      uarh_pkg::D_DATA: begin
        // The final byte arrives with the descriptor, the rest from the buffer.
        res_kind = uarh_pkg::KIND_DATA;
        res_data = is_last ? cur.value : rd_data_i;
      end
      default: begin
        res_status = cur.status;
        res_code   = cur.code;
      end
    endcase
  end

  // Burst tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (gen) begin
      busy_q <= !is_last;
      idx_q  <= cur_idx + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen && !busy_q) begin
      hold_q <= desc_i;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= gen;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (gen) begin
      out_kind_q   <= res_kind;
      out_tx_q     <= res_tx;
      out_data_q   <= res_data;
      out_status_q <= res_status;
      out_code_q   <= res_code;
      out_last_q   <= is_last;
      out_cnt_q    <= cnt_i;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {5'b00000, out_cnt_q, out_code_q, out_status_q, out_data_q, out_tx_q};

endmodule

>>> hdl/uart_register_access_host_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register access host - top level
// Host side of a sensor register protocol over a byte link.
// ----------------------------------------------------------------------------
// Each input word is a read request, a write request, a received link byte or
// a timer tick; the block answers with the bytes to transmit, the read data
// (released only once a whole read succeeded) or a single status word, the
// last word of each answer marked with tlast. Every output word also carries
// the four saturating error counters as they stand after that input. Words
// that cause no result are taken one per cycle; one that causes results waits
// until the emitter is idle and its output register free, which then emits one
// word per cycle while m_axis_tready is high: four for a read command, five for
// a write command, and up to MAX_READ_BYTES for a completed read. The timeout
// register may be written at any time the block is idle; it resets to 30.
module uart_register_access_host_unit #(
  parameter int unsigned MAX_READ_BYTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input words.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: reg_address[7:0], read_length[13:8], write_value[21:14],
  //        rx_value[29:22], zero fill[31:30]
  input  logic [31:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // Result words.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: tx_value[7:0], data_value[15:8], status[18:16], chip_code[26:19],
  //        count_no_answer[58:27], count_overrun[90:59],
  //        count_format[122:91], count_other[154:123], zero fill[159:155]
  output logic [159:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // Timeout register write.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  `include "uart_register_access_host_unit_defines.svh"

  localparam int unsigned IDX_W = (MAX_READ_BYTES > 1) ? $clog2(MAX_READ_BYTES) : 1;

  logic [uarh_pkg::TIMER_W-1:0] timeout_q;
  logic                         can_take;
  logic                         desc_valid;
  uarh_pkg::desc_t              desc;
  uarh_pkg::cnt_arr_t           cnt;
  logic [IDX_W-1:0]             rd_idx;
  logic [7:0]                   rd_data;

  // Timeout register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= uarh_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  uarh_seq #(
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .timeout_i    (timeout_q),
    .can_take_i   (can_take),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .cnt_o        (cnt),
    .rd_idx_i     (rd_idx),
    .rd_data_o    (rd_data)
  );

  uarh_emit #(
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .cnt_i        (cnt),
    .can_take_o   (can_take),
    .rd_idx_o     (rd_idx),
    .rd_data_i    (rd_data),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser),
    .m_tlast_o    (m_axis_tlast)
  );

  // A burst is only handed over when the emitter can start it.
  `UARH_ASSERT_IMPL(a_desc_taken, desc_valid && desc.kind != uarh_pkg::D_NONE, can_take, "burst handed to a busy emitter")

  // Status answers are always a single, final word.
  `UARH_ASSERT_IMPL(a_status_last, m_axis_tvalid && m_axis_tuser == uarh_pkg::KIND_STATUS, m_axis_tlast, "status word without tlast")

  // Read data words carry no transmit byte and an ok status.
  `UARH_ASSERT_IMPL(a_data_clean, m_axis_tvalid && m_axis_tuser == uarh_pkg::KIND_DATA, m_axis_tdata[7:0] == 8'h00 && m_axis_tdata[18:16] == uarh_pkg::ST_OK, "data word with stray fields")

  // A write command burst keeps the emitter from taking a new burst in the next cycle.
  `UARH_ASSERT_NEXT(a_burst_blocks, desc_valid && desc.kind == uarh_pkg::D_WRCMD, !can_take, "input taken during a command burst")

endmodule

>>> tb/uarh_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register access host - reply checker
// Watches the input, result and timeout channels of the host unit, predicts
// the result words of every accepted input word from its own copy of the
// protocol state, and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module uarh_reply_checker
  import uarh_pkg::*;
#(
  parameter int unsigned MAX_READ_BYTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input channel as seen at the block.
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [31:0]  in_data_i,
  input  logic [1:0]   in_user_i,
  // Result channel as seen at the block.
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [159:0] out_data_i,
  input  logic [1:0]   out_user_i,
  input  logic         out_last_i,
  // Timeout register write.
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [15:0]  cfg_data_i,
  // Status toward the stimulus side.
  output int unsigned  fail_cnt_o,
  output int unsigned  pending_o,
  output int unsigned  words_in_o,
  output int unsigned  words_out_o,
  output int unsigned  data_words_o,
  output logic         proto_idle_o,
  output logic [7:0]   status_seen_o
);

  // One expected result word, counters as they stand after its input.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx;
    logic [7:0] data;
    status_e    status;
    logic [7:0] code;
    logic       last;
    cnt_arr_t   cnt;
  } reply_t;

  // Predicted protocol state.
  phase_e             link_phase;
  logic [LEN_W-1:0]   pend_len;
  logic [LEN_W-1:0]   rx_count;
  logic [7:0]         hdr_byte;
  logic [TIMER_W-1:0] wait_ticks;
  logic [TIMER_W-1:0] tmo_ticks;
  logic [7:0]         read_buf [MAX_READ_BYTES];
  cnt_arr_t           err_cnt;

  reply_t      reply_q [$];
  int unsigned fails;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_data;
  logic [7:0]  status_seen;

  task automatic queue_reply(input kind_e kind, input logic [7:0] tx,
                             input logic [7:0] data, input status_e status,
                             input logic [7:0] code, input logic last);
    reply_t r;
    r.kind   = kind;
    r.tx     = tx;
    r.data   = data;
    r.status = status;
    r.code   = code;
    r.last   = last;
    r.cnt    = err_cnt;
    reply_q.push_back(r);
  endtask

  // Bump the saturating counter that an error code belongs to.
  task automatic count_failure(input logic [7:0] code);
    cls_e slot;
    case (code)
      CODE_NO_ANSWER:              slot = CLS_NO_ANSWER;
      CODE_OVERRUN:                slot = CLS_OVERRUN;
      CODE_BAD_HDR, CODE_BAD_DATA: slot = CLS_FORMAT;
      default:                     slot = CLS_OTHER;
    endcase
    if (err_cnt[slot] != '1) begin
      err_cnt[slot] = err_cnt[slot] + 1'b1;
    end
  endtask

  // End the current request with a single status word.
  task automatic close_request(input status_e status, input logic [7:0] code);
    link_phase = PH_IDLE;
    wait_ticks = '0;
    queue_reply(KIND_STATUS, 8'h00, 8'h00, status, code, 1'b1);
  endtask

  // Work out the result words of one accepted input word.
  task automatic predict_replies(input op_e op, input logic [7:0] addr,
                                 input logic [5:0] len, input logic [7:0] wval,
                                 input logic [7:0] rx);
    case (op)
      OP_READ, OP_WRITE: begin
        if (link_phase != PH_IDLE) begin
          queue_reply(KIND_STATUS, 8'h00, 8'h00, ST_BUSY, 8'h00, 1'b1);
        end else if (op == OP_READ && (len == 0 || len > MAX_READ_BYTES)) begin
          queue_reply(KIND_STATUS, 8'h00, 8'h00, ST_BAD_LENGTH, 8'h00, 1'b1);
        end else begin
          queue_reply(KIND_TX, BYTE_SYNC, 8'h00, ST_OK, 8'h00, 1'b0);
          if (op == OP_READ) begin
            queue_reply(KIND_TX, BYTE_CMD_READ, 8'h00, ST_OK, 8'h00, 1'b0);
            queue_reply(KIND_TX, addr, 8'h00, ST_OK, 8'h00, 1'b0);
            queue_reply(KIND_TX, {2'b00, len}, 8'h00, ST_OK, 8'h00, 1'b1);
            pend_len   = len;
            link_phase = PH_HDR;
          end else begin
            queue_reply(KIND_TX, BYTE_CMD_WRITE, 8'h00, ST_OK, 8'h00, 1'b0);
            queue_reply(KIND_TX, addr, 8'h00, ST_OK, 8'h00, 1'b0);
            queue_reply(KIND_TX, BYTE_WR_LEN, 8'h00, ST_OK, 8'h00, 1'b0);
            queue_reply(KIND_TX, wval, 8'h00, ST_OK, 8'h00, 1'b1);
            pend_len   = '0;
            link_phase = PH_ACK1;
          end
          rx_count   = '0;
          hdr_byte   = 8'h00;
          wait_ticks = '0;
        end
      end
      OP_RX: begin
        case (link_phase)
          PH_HDR: begin
            hdr_byte   = rx;
            link_phase = PH_LEN;
          end
          PH_LEN: begin
            if (hdr_byte == BYTE_RESP_ERR) begin
              count_failure(rx);
              close_request(ST_CHIP_ERROR, rx);
            end else if (hdr_byte != BYTE_RESP_HDR || rx != {2'b00, pend_len}) begin
              count_failure(CODE_BAD_HDR);
              close_request(ST_BAD_FRAME, 8'h00);
            end else begin
              link_phase = PH_DATA;
              rx_count   = '0;
              wait_ticks = '0;
            end
          end
          PH_DATA: begin
            if (rx_count < MAX_READ_BYTES) begin
              read_buf[rx_count] = rx;
            end
            rx_count = rx_count + 1'b1;
            // The whole block has arrived: release the buffered bytes.
            if (rx_count >= pend_len) begin
              for (int i = 0; i < pend_len && i < MAX_READ_BYTES; i++) begin
                queue_reply(KIND_DATA, 8'h00, read_buf[i], ST_OK, 8'h00,
                            i + 1 == pend_len);
              end
              link_phase = PH_IDLE;
              wait_ticks = '0;
            end
          end
          PH_ACK1: begin
            hdr_byte   = rx;
            link_phase = PH_ACK2;
          end
          PH_ACK2: begin
            if (hdr_byte == BYTE_RESP_ERR && rx == BYTE_ACK_OK) begin
              close_request(ST_OK, 8'h00);
            end else begin
              close_request(ST_WRITE_REFUSED, 8'h00);
            end
          end
          default: begin
            link_phase = PH_IDLE;
          end
        endcase
      end
      default: begin
        // Timer tick: only a pending wait counts it.
        if (link_phase != PH_IDLE) begin
          if (wait_ticks != '1) begin
            wait_ticks = wait_ticks + 1'b1;
          end
          if (wait_ticks >= tmo_ticks) begin
            case (link_phase)
              PH_HDR, PH_LEN: begin
                count_failure(CODE_NO_ANSWER);
                close_request(ST_NO_ANSWER, 8'h00);
              end
              PH_DATA: begin
                count_failure(CODE_BAD_DATA);
                close_request(ST_SHORT_DATA, 8'h00);
              end
              default: begin
                close_request(ST_NO_ANSWER, 8'h00);
              end
            endcase
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: result word with nothing expected, tuser %0d tdata %h",
               $time, out_user_i, out_data_i);
      fails++;
    end else begin
      want = reply_q.pop_front();
      check_field("kind", want.kind, out_user_i);
      check_field("tx_value", want.tx, out_data_i[7:0]);
      check_field("data_value", want.data, out_data_i[15:8]);
      check_field("status", want.status, out_data_i[18:16]);
      check_field("chip_code", want.code, out_data_i[26:19]);
      check_field("last", want.last, out_last_i);
      check_field("count_no_answer", want.cnt[CLS_NO_ANSWER], out_data_i[58:27]);
      check_field("count_overrun", want.cnt[CLS_OVERRUN], out_data_i[90:59]);
      check_field("count_format", want.cnt[CLS_FORMAT], out_data_i[122:91]);
      check_field("count_other", want.cnt[CLS_OTHER], out_data_i[154:123]);
      if (want.kind == KIND_DATA) begin
        n_data++;
      end
      if (want.kind == KIND_STATUS) begin
        status_seen[want.status] = 1'b1;
      end
    end
    n_out++;
  endtask

  // Results are checked before the same edge's input word is predicted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      link_phase  = PH_IDLE;
      pend_len    = '0;
      rx_count    = '0;
      hdr_byte    = 8'h00;
      wait_ticks  = '0;
      tmo_ticks   = TIMEOUT_RESET;
      err_cnt     = '0;
      fails       = 0;
      n_in        = 0;
      n_out       = 0;
      n_data      = 0;
      status_seen = 8'h00;
      reply_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_reply();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        tmo_ticks = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        n_in++;
        predict_replies(op_e'(in_user_i), in_data_i[7:0], in_data_i[13:8],
                        in_data_i[21:14], in_data_i[29:22]);
      end
    end
    fail_cnt_o    <= fails;
    pending_o     <= reply_q.size();
    words_in_o    <= n_in;
    words_out_o   <= n_out;
    data_words_o  <= n_data;
    proto_idle_o  <= (link_phase == PH_IDLE);
    status_seen_o <= status_seen;
  end

endmodule

>>> tb/tb_uart_register_access_host_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register access host - testbench top
// Drives read and write requests, reply bytes and timer ticks into the host
// unit under random idling and back-pressure, walks the timeout register
// through several settings, and reports the verdict of the reply checker.
// ----------------------------------------------------------------------------
module tb_uart_register_access_host_unit;
  import uarh_pkg::*;

  localparam int unsigned MAX_READ = 16;
  localparam int unsigned SETTLE   = 20;
  localparam int unsigned LIMIT    = 2_000_000;
  localparam int unsigned STALL_AT = 150;

  logic         clk_i;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data   = '0;

  int unsigned fails;
  int unsigned pending;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned data_words;
  logic        proto_idle;
  logic [7:0]  status_seen;

  bit          idling_on = 1'b1;
  logic [15:0] tmo_now   = TIMEOUT_RESET;
  int unsigned words_sent = 0;
  int unsigned cycle_cnt  = 0;

  uart_register_access_host_unit #(
    .MAX_READ_BYTES(MAX_READ)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(in_tvalid),
    .s_axis_tready(in_tready),
    .s_axis_tdata (in_tdata),
    .s_axis_tuser (in_tuser),
    .m_axis_tvalid(out_tvalid),
    .m_axis_tready(out_tready),
    .m_axis_tdata (out_tdata),
    .m_axis_tuser (out_tuser),
    .m_axis_tlast (out_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  uarh_reply_checker #(
    .MAX_READ_BYTES(MAX_READ)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_tvalid),
    .in_ready_i   (in_tready),
    .in_data_i    (in_tdata),
    .in_user_i    (in_tuser),
    .out_valid_i  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_data_i   (out_tdata),
    .out_user_i   (out_tuser),
    .out_last_i   (out_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_cnt_o   (fails),
    .pending_o    (pending),
    .words_in_o   (words_in),
    .words_out_o  (words_out),
    .data_words_o (data_words),
    .proto_idle_o (proto_idle),
    .status_seen_o(status_seen)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Run stopped at the cycle limit of %0d", LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off once traffic is flowing.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_in >= STALL_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      out_tready <= !(idling_on && $urandom_range(99) < 9);
    end
  end

  // Offer one input word and wait until it is taken. Called right after an edge.
  task automatic push_word(input op_e op, input logic [7:0] addr,
                           input logic [5:0] len, input logic [7:0] wval,
                           input logic [7:0] rx);
    while (idling_on && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rx, wval, len, addr};
    in_tuser  <= op;
    @(posedge clk_i);
    while (!in_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic rx_byte(input logic [7:0] b);
    push_word(OP_RX, 8'($urandom), 6'($urandom), 8'($urandom), b);
  endtask

  task automatic tick();
    push_word(OP_TICK, 8'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic read_req(input logic [7:0] addr, input logic [5:0] len);
    push_word(OP_READ, addr, len, 8'($urandom), 8'($urandom));
  endtask

  task automatic write_req(input logic [7:0] addr, input logic [7:0] wval);
    push_word(OP_WRITE, addr, 6'($urandom), wval, 8'($urandom));
  endtask

  // Tick until the pending request has ended; the idle flag lags one word.
  task automatic to_idle();
    do begin
      tick();
    end while (!proto_idle);
  endtask

  // Occasionally a tick inside a wait, always short of the timeout.
  task automatic spread_ticks(inout int unsigned used);
    if ($urandom_range(9) == 0 && used + 1 < tmo_now) begin
      tick();
      used++;
    end
  endtask

  // Write the timeout register once every expected word has come back.
  task automatic set_timeout(input logic [15:0] ticks);
    in_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    tmo_now = ticks;
  endtask

  // Complete read: request, BB len header and the data block.
  task automatic good_read(input logic [7:0] addr, input logic [5:0] len);
    int unsigned used;
    used = 0;
    read_req(addr, len);
    if ($urandom_range(9) == 0) begin
      push_word(op_e'($urandom_range(1)), 8'($urandom), 6'($urandom),
                8'($urandom), 8'($urandom));
    end
    spread_ticks(used);
    rx_byte(BYTE_RESP_HDR);
    spread_ticks(used);
    rx_byte({2'b00, len});
    used = 0;
    repeat (len) begin
      spread_ticks(used);
      rx_byte(8'($urandom));
    end
  endtask

  // Write with an acknowledge that is mostly EE 01.
  task automatic good_write(input logic [7:0] addr, input logic [7:0] wval);
    int unsigned used;
    used = 0;
    write_req(addr, wval);
    spread_ticks(used);
    rx_byte($urandom_range(4) != 0 ? BYTE_RESP_ERR : 8'($urandom));
    spread_ticks(used);
    rx_byte($urandom_range(4) != 0 ? BYTE_ACK_OK : 8'($urandom));
  endtask

  // Random traffic: mostly well-formed exchanges, the rest errors and noise.
  task automatic random_mix(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned part;
    logic [5:0]  len;
    logic [7:0]  code;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(99);
      len  = $urandom_range(3) != 0 ? 6'($urandom_range(4, 1))
                                    : 6'($urandom_range(MAX_READ, 1));
      if (pick < 40) begin
        good_read(8'($urandom), len);
      end else if (pick < 55) begin
        good_write(8'($urandom), 8'($urandom));
      end else if (pick < 65) begin
        // Chip error frame with a code from each counter class.
        case ($urandom_range(4))
          0:       code = CODE_OVERRUN;
          1:       code = CODE_BAD_HDR;
          2:       code = CODE_BAD_DATA;
          3:       code = CODE_NO_ANSWER;
          default: code = 8'($urandom);
        endcase
        read_req(8'($urandom), len);
        rx_byte(BYTE_RESP_ERR);
        rx_byte(code);
      end else if (pick < 73) begin
        // Broken header or length.
        read_req(8'($urandom), len);
        rx_byte($urandom_range(1) ? BYTE_RESP_HDR : 8'($urandom));
        rx_byte($urandom_range(1) ? {2'b00, len + 6'd1} : 8'($urandom));
        to_idle();
      end else if (pick < 85) begin
        // No answer or an answer cut short.
        part = $urandom_range(2);
        if ($urandom_range(1)) begin
          read_req(8'($urandom), len);
          if (part != 0) begin
            rx_byte(part == 1 ? 8'($urandom) : BYTE_RESP_HDR);
          end
          if (part == 2) begin
            rx_byte({2'b00, len});
            repeat ($urandom_range(len - 1)) rx_byte(8'($urandom));
          end
        end else begin
          write_req(8'($urandom), 8'($urandom));
          if (part != 0) begin
            rx_byte(8'($urandom));
          end
        end
        to_idle();
      end else if (pick < 91) begin
        read_req(8'($urandom), $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, 17)));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          push_word(op_e'($urandom_range(3)), 8'($urandom), 6'($urandom),
                    8'($urandom), 8'($urandom));
        end
        to_idle();
      end
    end
  endtask

  // Main stimulus.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset timeout: an unanswered read must fail on the 30th tick.
    tick();
    rx_byte(8'h55);
    read_req(8'h10, 6'd2);
    to_idle();

    // Directed cases with the shortest timeout, where one tick ends a wait.
    set_timeout(16'd1);
    good_read(8'h00, 6'd1);
    good_read(8'hFF, 6'd16);
    rx_byte(8'hAB);
    read_req(8'h21, 6'd0);
    read_req(8'h22, 6'd17);
    read_req(8'h23, 6'd63);
    read_req(8'h3C, 6'd2);
    read_req(8'h3D, 6'd1);
    write_req(8'h3E, 8'h77);
    rx_byte(BYTE_RESP_ERR);
    rx_byte(CODE_OVERRUN);
    read_req(8'h40, 6'd1);
    rx_byte(BYTE_RESP_ERR);
    rx_byte(CODE_BAD_HDR);
    read_req(8'h41, 6'd1);
    rx_byte(BYTE_RESP_ERR);
    rx_byte(CODE_NO_ANSWER);
    read_req(8'h42, 6'd1);
    rx_byte(BYTE_RESP_ERR);
    rx_byte(8'h42);
    read_req(8'h50, 6'd3);
    rx_byte(8'h12);
    rx_byte(8'h03);
    read_req(8'h51, 6'd3);
    rx_byte(BYTE_RESP_HDR);
    rx_byte(8'h04);
    read_req(8'h60, 6'd2);
    tick();
    read_req(8'h61, 6'd2);
    rx_byte(BYTE_RESP_HDR);
    tick();
    read_req(8'h62, 6'd4);
    rx_byte(BYTE_RESP_HDR);
    rx_byte(8'h04);
    rx_byte(8'hFF);
    rx_byte(8'h00);
    tick();
    write_req(8'h5A, 8'hFF);
    rx_byte(BYTE_RESP_ERR);
    rx_byte(BYTE_ACK_OK);
    write_req(8'h00, 8'h00);
    rx_byte(BYTE_RESP_ERR);
    rx_byte(8'h02);
    write_req(8'h5B, 8'h01);
    rx_byte(BYTE_RESP_HDR);
    rx_byte(BYTE_ACK_OK);
    write_req(8'h5C, 8'h02);
    tick();
    write_req(8'h5D, 8'h03);
    rx_byte(BYTE_RESP_ERR);
    tick();

    // Random traffic under several timeouts; one stretch without idling.
    set_timeout(16'd3);
    random_mix(90);
    set_timeout(16'd7);
    idling_on = 1'b0;
    random_mix(80);
    idling_on = 1'b1;
    set_timeout(16'd2);
    random_mix(80);

    // Longest timeout: the wait counter runs all the way to its top value.
    set_timeout(16'hFFFF);
    good_read(8'h70, 6'd3);
    good_write(8'h71, 8'h5A);
    read_req(8'h72, 6'd5);
    rx_byte(BYTE_RESP_HDR);
    rx_byte(8'h05);
    rx_byte(8'hC3);
    to_idle();

    // Drain and give the verdict.
    in_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d input words and %0d result words, %0d of them read data.",
             words_in, words_out, data_words);
    $display("Timeouts 30, 1, 3, 7, 2 and 65535 ticks; status codes seen (bit per code): %b",
             status_seen);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
